/* src/spq_pkg.sv */
`timescale 1ns / 1ps
// Shared constants and types for the sorted priority queue.
// Used by spq_cell and sorted_priority_queue; depends on nothing else.
`default_nettype none

package spq_pkg;

  localparam int unsigned DEPTH  = 8;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned RANK_W = 8;
  localparam int unsigned REQ_W  = 2;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned OCC_W  = 4;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_ENQ  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DEQ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_PEEK = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic enq;
    logic deq;
  } spq_ctrl_t;

endpackage

`default_nettype wire

/* src/spq_cell.sv */
`timescale 1ns / 1ps
// One slot of the sorted queue: holds a word and its priority, shifts with neighbours.
// Depends on spq_pkg.
`default_nettype none

module spq_cell (
  input  wire logic                              clk_i,
  input  wire spq_pkg::spq_ctrl_t                ctrl_i,
  input  wire logic                              occ_i,        // slot holds an entry
  input  wire logic signed [spq_pkg::VAL_W-1:0]  new_value_i,
  input  wire logic        [spq_pkg::RANK_W-1:0] new_rank_i,
  input  wire logic                              left_stay_i,  // left neighbour keeps its entry
  input  wire logic signed [spq_pkg::VAL_W-1:0]  left_value_i,
  input  wire logic        [spq_pkg::RANK_W-1:0] left_rank_i,
  input  wire logic signed [spq_pkg::VAL_W-1:0]  right_value_i,
  input  wire logic        [spq_pkg::RANK_W-1:0] right_rank_i,
  output logic                                   stay_o,
  output logic signed      [spq_pkg::VAL_W-1:0]  value_o,
  output logic             [spq_pkg::RANK_W-1:0] rank_o
);

  logic signed [spq_pkg::VAL_W-1:0]  value_q, value_d;
  logic        [spq_pkg::RANK_W-1:0] rank_q, rank_d;

  // Equal priority stays ahead of the newcomer
  assign stay_o = occ_i && (rank_q <= new_rank_i);

  always_comb begin
    value_d = value_q;
    rank_d  = rank_q;
    if (ctrl_i.enq && !stay_o) begin
      if (left_stay_i) begin
        value_d = new_value_i;
        rank_d  = new_rank_i;
      end else begin
        value_d = left_value_i;
        rank_d  = left_rank_i;
      end
    end else if (ctrl_i.deq) begin
      value_d = right_value_i;
      rank_d  = right_rank_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    rank_q  <= rank_d;
  end

  assign value_o = value_q;
  assign rank_o  = rank_q;

endmodule

`default_nettype wire

/* src/sorted_priority_queue.sv */
`timescale 1ns / 1ps
// Top level of the sorted priority queue: a row of spq_cell slots plus count and result register.
// Depends on spq_pkg and spq_cell.
//
//  Channel   Direction  Payload
//  s_axis    in         tuser: req_type; tdata: item_value, item_rank
//  m_axis    out        tuser: status;   tdata: head_value, head_rank, occupancy,
//                                               now_empty, now_full
//
// Cycles: one request per clock while s_axis_tready is high. Every cell decides its next
// contents in the same cycle from a single rank compare against the incoming word, so the
// insert or remove of a whole row settles at the same edge that loads the output register.
// Reset clears the entry count and the result-valid flag; slot contents are not cleared,
// since only slots below the count are ever read.
// Stalls: s_axis_tready drops only while a result waits in the output register and the
// sink holds m_axis_tready low.
`default_nettype none

module sorted_priority_queue (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // [31:0] item_value, [39:32] item_rank
  input  wire logic [1:0]  s_axis_tuser,  // [1:0] req_type
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,  // [31:0] head_value, [39:32] head_rank,
                                          // [43:40] occupancy, [44] now_empty,
                                          // [45] now_full, [47:46] zero
  output logic [1:0]       m_axis_tuser   // [1:0] status
);

  localparam int unsigned DEPTH = spq_pkg::DEPTH;
  localparam int unsigned CNT_W = spq_pkg::CNT_W;

  // Input fields
  logic                              accept;
  logic        [spq_pkg::REQ_W-1:0]  req_type;
  logic signed [spq_pkg::VAL_W-1:0]  item_value;
  logic        [spq_pkg::RANK_W-1:0] item_rank;

  assign req_type   = s_axis_tuser;
  assign item_value = s_axis_tdata[31:0];
  assign item_rank  = s_axis_tdata[39:32];
  assign accept     = s_axis_tvalid && s_axis_tready;

  // Entry count
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             is_full, is_empty;
  logic             is_read;

  assign is_full  = (cnt_q == CNT_W'(DEPTH));
  assign is_empty = (cnt_q == '0);
  assign is_read  = (req_type == spq_pkg::REQ_DEQ) || (req_type == spq_pkg::REQ_PEEK);

  spq_pkg::spq_ctrl_t ctrl;

  // Commit only legal requests; rejected ones leave the row untouched
  assign ctrl.enq = accept && (req_type == spq_pkg::REQ_ENQ) && !is_full;
  assign ctrl.deq = accept && (req_type == spq_pkg::REQ_DEQ) && !is_empty;

  always_comb begin
    cnt_d = cnt_q;
    if (ctrl.enq) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (ctrl.deq) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  // Cell row; slot 0 is the front
  logic                              occ     [DEPTH];
  logic                              stay    [DEPTH];
  logic signed [spq_pkg::VAL_W-1:0]  value_w [DEPTH];
  logic        [spq_pkg::RANK_W-1:0] rank_w  [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                              left_stay;
    logic signed [spq_pkg::VAL_W-1:0]  left_value;
    logic        [spq_pkg::RANK_W-1:0] left_rank;
    logic signed [spq_pkg::VAL_W-1:0]  right_value;
    logic        [spq_pkg::RANK_W-1:0] right_rank;

    assign occ[i] = (CNT_W'(i) < cnt_q);

    if (i == 0) begin : g_front
      // Nothing ahead of the front slot: a newcomer lands here if the front moves back
      assign left_stay  = 1'b1;
      assign left_value = item_value;
      assign left_rank  = item_rank;
    end else begin : g_mid
      assign left_stay  = stay[i-1];
      assign left_value = value_w[i-1];
      assign left_rank  = rank_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_back
      // The back slot falls out of the count on a dequeue; fill it with zeros
      assign right_value = '0;
      assign right_rank  = '0;
    end else begin : g_inner
      assign right_value = value_w[i+1];
      assign right_rank  = rank_w[i+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occ_i        (occ[i]),
      .new_value_i  (item_value),
      .new_rank_i   (item_rank),
      .left_stay_i  (left_stay),
      .left_value_i (left_value),
      .left_rank_i  (left_rank),
      .right_value_i(right_value),
      .right_rank_i (right_rank),
      .stay_o       (stay[i]),
      .value_o      (value_w[i]),
      .rank_o       (rank_w[i])
    );
  end

  // Result fields for the beat being accepted
  logic        [spq_pkg::STAT_W-1:0] status_d;
  logic signed [spq_pkg::VAL_W-1:0]  head_value_d;
  logic        [spq_pkg::RANK_W-1:0] head_rank_d;

  always_comb begin
    status_d     = spq_pkg::ST_DONE;
    head_value_d = '0;
    head_rank_d  = '0;
    if (req_type == spq_pkg::REQ_ENQ) begin
      if (is_full) begin
        status_d = spq_pkg::ST_FULL;
      end
    end else if (is_read) begin
      if (is_empty) begin
        status_d = spq_pkg::ST_EMPTY;
      end else begin
        head_value_d = value_w[0];
        head_rank_d  = rank_w[0];
      end
    end
  end

  // Output register: refill whenever it is empty or being drained
  logic                              out_vld_q;
  logic        [spq_pkg::STAT_W-1:0] status_q;
  logic signed [spq_pkg::VAL_W-1:0]  head_value_q;
  logic        [spq_pkg::RANK_W-1:0] head_rank_q;
  logic        [spq_pkg::OCC_W-1:0]  occ_q;
  logic                              empty_q, full_q;

  assign s_axis_tready = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (accept) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q     <= status_d;
      head_value_q <= head_value_d;
      head_rank_q  <= head_rank_d;
      occ_q        <= spq_pkg::OCC_W'(cnt_d);
      empty_q      <= (cnt_d == '0);
      full_q       <= (cnt_d == CNT_W'(DEPTH));
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {2'b00, full_q, empty_q, occ_q, head_rank_q, head_value_q};

`ifndef SYNTH
  // Count never runs past the row length
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("entry count exceeds depth");

  // An enqueue into a full row is rejected
  a_full_reject : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_type == spq_pkg::REQ_ENQ) && is_full)
      |=> (m_axis_tuser == spq_pkg::ST_FULL) && (cnt_q == $past(cnt_q)))
    else $error("enqueue on full row not rejected");

  // A legal dequeue removes exactly one entry
  a_deq_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.deq |=> (cnt_q == $past(cnt_q) - CNT_W'(1)))
    else $error("dequeue did not drop one entry");

  // A set empty flag comes with zero reported occupancy while the row is empty
  a_empty_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[44] == (m_axis_tdata[43:40] == 4'd0 && cnt_q == '0))
                      || !(cnt_q == '0) || !m_axis_tdata[44])
    else $error("empty flag inconsistent");

  // Front slot's rank is no larger than the next slot's when two or more entries are held
  a_front_min : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q >= CNT_W'(2)) && (DEPTH > 1) |-> (rank_w[0] <= rank_w[DEPTH > 1 ? 1 : 0]))
    else $error("front entry is not the minimum");
`endif

endmodule

`default_nettype wire

/* tb/tb_sorted_priority_queue.sv */
`timescale 1ns / 1ps
// Self-checking testbench for sorted_priority_queue: enqueue, dequeue and peek requests
// are checked beat by beat against an in-bench model of the sorted row.
// Depends on spq_pkg and the sorted_priority_queue RTL only.

module tb_sorted_priority_queue;

  // Code 3 has no meaning; the block must answer it as done with the row untouched.
  localparam logic [spq_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

  localparam int unsigned STALL_LIMIT = 1000;  // cycles without any beat before giving up
  localparam int unsigned TAIL_CYCLES = 4;     // output register plus margin
  localparam int unsigned RANDOM_ITEMS = 1600;
  localparam int unsigned PRINT_CAP = 50;

  // One expected response beat, fields at the block's widths.
  typedef struct packed {
    logic [spq_pkg::STAT_W-1:0] status;
    logic [spq_pkg::VAL_W-1:0]  head_value;
    logic [spq_pkg::RANK_W-1:0] head_rank;
    logic [spq_pkg::OCC_W-1:0]  occupancy;
    logic                       now_empty;
    logic                       now_full;
  } served_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;  // [31:0] item_value, [39:32] item_rank
  logic [1:0]  s_axis_tuser = '0;  // [1:0] req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;       // [31:0] head_value, [39:32] head_rank, [43:40] occupancy,
                                   // [44] now_empty, [45] now_full, [47:46] zero
  logic [1:0]  m_axis_tuser;       // [1:0] status

  sorted_priority_queue uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Model of the sorted row: slot 0 is the front, ties kept in arrival order.
  // ---------------------------------------------------------------------------
  logic [spq_pkg::VAL_W-1:0]  row_value [spq_pkg::DEPTH];
  logic [spq_pkg::RANK_W-1:0] row_rank  [spq_pkg::DEPTH];
  int unsigned                row_count = 0;

  served_t     awaited_results [$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;

  // Apply one request to the model and return the beat it should produce.
  function automatic served_t serve_request(logic [spq_pkg::REQ_W-1:0] req,
                                            logic [spq_pkg::VAL_W-1:0] value,
                                            logic [spq_pkg::RANK_W-1:0] rank);
    served_t     res;
    int unsigned pos;
    res = '0;
    res.status = spq_pkg::ST_DONE;
    if (req == spq_pkg::REQ_ENQ) begin
      if (row_count >= spq_pkg::DEPTH) begin
        res.status = spq_pkg::ST_FULL;
      end else begin
        // Go behind every held entry of equal or lower rank.
        pos = 0;
        while (pos < row_count && row_rank[pos] <= rank) pos++;
        for (int i = row_count; i > pos; i--) begin
          row_value[i] = row_value[i-1];
          row_rank[i]  = row_rank[i-1];
        end
        row_value[pos] = value;
        row_rank[pos]  = rank;
        row_count++;
      end
    end else if (req == spq_pkg::REQ_DEQ || req == spq_pkg::REQ_PEEK) begin
      if (row_count == 0) begin
        res.status = spq_pkg::ST_EMPTY;
      end else begin
        res.head_value = row_value[0];
        res.head_rank  = row_rank[0];
        if (req == spq_pkg::REQ_DEQ) begin
          for (int i = 0; i + 1 < row_count; i++) begin
            row_value[i] = row_value[i+1];
            row_rank[i]  = row_rank[i+1];
          end
          row_count--;
        end
      end
    end
    res.occupancy = spq_pkg::OCC_W'(row_count);
    res.now_empty = (row_count == 0);
    res.now_full  = (row_count >= spq_pkg::DEPTH);
    return res;
  endfunction

  // Predict on every accepted request beat.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      awaited_results.push_back(serve_request(s_axis_tuser, s_axis_tdata[31:0],
                                              s_axis_tdata[39:32]));
    end
  end

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("[%0t] result %0d: %s got %h want %h", $realtime, results_seen, field, got, want);
    end
  endtask

  // Compare every accepted result beat with the oldest expectation.
  always @(posedge clk_i) begin
    served_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        report_mismatch("unexpected beat", m_axis_tdata[31:0], 32'd0);
      end else begin
        want = awaited_results.pop_front();
        if (m_axis_tuser != want.status)
          report_mismatch("status", 32'(m_axis_tuser), 32'(want.status));
        if (m_axis_tdata[31:0] != want.head_value)
          report_mismatch("head_value", m_axis_tdata[31:0], want.head_value);
        if (m_axis_tdata[39:32] != want.head_rank)
          report_mismatch("head_rank", 32'(m_axis_tdata[39:32]), 32'(want.head_rank));
        if (m_axis_tdata[43:40] != want.occupancy)
          report_mismatch("occupancy", 32'(m_axis_tdata[43:40]), 32'(want.occupancy));
        if (m_axis_tdata[44] != want.now_empty)
          report_mismatch("now_empty", 32'(m_axis_tdata[44]), 32'(want.now_empty));
        if (m_axis_tdata[45] != want.now_full)
          report_mismatch("now_full", 32'(m_axis_tdata[45]), 32'(want.now_full));
        if (m_axis_tdata[47:46] != 2'b00)
          report_mismatch("pad bits", 32'(m_axis_tdata[47:46]), 32'd0);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sink: hold tready in one of three moods, picked anew at random after each span.
  // ---------------------------------------------------------------------------
  int unsigned sink_mode = 0;
  int unsigned sink_span = 0;
  int unsigned sink_hold = 0;

  always @(posedge clk_i) begin
    if (sink_span == 0) begin
      sink_mode <= $urandom_range(2, 0);
      sink_span <= $urandom_range(200, 40);
    end else begin
      sink_span <= sink_span - 1;
    end
    case (sink_mode)
      0: m_axis_tready <= 1'b1;                          // no back-pressure at all
      1: m_axis_tready <= ($urandom_range(9, 0) < 7);    // scattered stalls
      default: begin                                     // long stalls, single ready cycles
        if (sink_hold != 0) begin
          sink_hold     <= sink_hold - 1;
          m_axis_tready <= 1'b0;
        end else begin
          sink_hold     <= $urandom_range(20, 1);
          m_axis_tready <= 1'b1;
        end
      end
    endcase
  end

  // Watchdog: end the run if no beat moves on either side for too long.
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("[%0t] watchdog: no beat for %0d cycles", $realtime, STALL_LIMIT);
      $display("tb_sorted_priority_queue NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Source: bursts of back-to-back beats with random gaps between them.
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;

  // Present one request beat and hold it until accepted. Called at a rising edge.
  task automatic send_request(input logic [spq_pkg::REQ_W-1:0] req,
                              input logic [spq_pkg::VAL_W-1:0] value,
                              input logic [spq_pkg::RANK_W-1:0] rank);
    int unsigned gap;
    if (burst_left == 0) begin
      // Mostly short bursts; now and then a long stretch with no idling.
      burst_left = ($urandom_range(9, 0) == 0) ? $urandom_range(200, 100) : $urandom_range(30, 1);
      gap = ($urandom_range(9, 0) < 3) ? 0 : $urandom_range(12, 1);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {rank, value};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Drop tvalid and wait until every expected result has come back. Wait for a clock edge
  // first so that the prediction for the last accepted beat is already queued.
  task automatic wait_for_results;
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Dequeue and peek on an empty row are rejected; the unused code is answered as done.
  task automatic test_empty_queue;
    send_request(spq_pkg::REQ_DEQ,  32'hFFFF_FFFF, 8'hFF);
    send_request(spq_pkg::REQ_PEEK, 32'h0000_0000, 8'h00);
    send_request(REQ_UNUSED,        32'hDEAD_BEEF, 8'hA5);
  endtask

  // Fill to DEPTH with rank extremes and ties, then push once more into the full row.
  task automatic test_fill_to_full;
    send_request(spq_pkg::REQ_ENQ, 32'h7FFF_FFFF, 8'd255);
    send_request(spq_pkg::REQ_ENQ, 32'h8000_0000, 8'd0);
    send_request(spq_pkg::REQ_ENQ, 32'h0000_0000, 8'd128);
    send_request(spq_pkg::REQ_ENQ, 32'hFFFF_FFFF, 8'd128);
    send_request(spq_pkg::REQ_ENQ, 32'h0000_0001, 8'd128);
    send_request(spq_pkg::REQ_ENQ, 32'h5555_5555, 8'd0);
    send_request(spq_pkg::REQ_ENQ, 32'hAAAA_AAAA, 8'd255);
    send_request(spq_pkg::REQ_ENQ, 32'h1234_5678, 8'd1);
    send_request(spq_pkg::REQ_ENQ, 32'hCAFE_F00D, 8'd0);   // rejected: row full
    send_request(spq_pkg::REQ_PEEK, 32'h0, 8'd0);
    send_request(REQ_UNUSED, 32'h0, 8'd0);
  endtask

  // Drain the row in rank order, ties first in first out, then one dequeue too many.
  task automatic test_drain_in_order;
    repeat (spq_pkg::DEPTH + 1)
      send_request(spq_pkg::REQ_DEQ, $urandom, spq_pkg::RANK_W'($urandom));
  endtask

  function automatic logic [spq_pkg::RANK_W-1:0] pick_rank;
    int unsigned roll;
    roll = $urandom_range(9, 0);
    if (roll < 5) return spq_pkg::RANK_W'($urandom_range(3, 0));     // dense ties
    if (roll < 7) return roll[0] ? 8'd255 : 8'd0;
    return spq_pkg::RANK_W'($urandom);
  endfunction

  function automatic logic [spq_pkg::VAL_W-1:0] pick_value;
    case ($urandom_range(15, 0))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Random traffic in phases that lean towards filling, draining or a mix.
  task automatic test_random_traffic(input int unsigned count);
    int unsigned lean;
    int unsigned roll;
    logic [spq_pkg::REQ_W-1:0] req;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) lean = $urandom_range(2, 0);
      roll = $urandom_range(99, 0);
      if (roll < 3) begin
        req = REQ_UNUSED;
      end else if (roll < 18) begin
        req = spq_pkg::REQ_PEEK;
      end else begin
        case (lean)
          0:       req = (roll < 75) ? spq_pkg::REQ_ENQ : spq_pkg::REQ_DEQ;  // fill past full
          1:       req = (roll < 42) ? spq_pkg::REQ_ENQ : spq_pkg::REQ_DEQ;  // drain past empty
          default: req = (roll < 59) ? spq_pkg::REQ_ENQ : spq_pkg::REQ_DEQ;
        endcase
      end
      send_request(req, pick_value(), pick_rank());
    end
  endtask

  // Hold the source off until the queue of expected results has emptied.
  task automatic test_pause_until_drained;
    wait_for_results();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_queue();
    test_fill_to_full();
    test_drain_in_order();
    test_random_traffic(RANDOM_ITEMS / 2);
    test_pause_until_drained();
    test_random_traffic(RANDOM_ITEMS - RANDOM_ITEMS / 2);

    // Let the last results out, then keep watching for stray beats.
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("tb_sorted_priority_queue OK");
    end else begin
      $display("tb_sorted_priority_queue NOT OK");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/spq_pkg.sv
src/spq_cell.sv
src/sorted_priority_queue.sv
tb/tb_sorted_priority_queue.sv
